// File: design/csm_pkg.sv
// Shared types and constants for the context steering map.
// Holds the command format passed from the front end to the executor, plus
// Q7.8 helpers. No dependencies.
package csm_pkg;

  // Fixed field widths of the item and result transfers, and the queue depth.
  localparam int WEIGHT_W    = 16;
  localparam int DIR_IN_W    = 3;
  localparam int BEST_W      = 4;
  localparam int FORCE_W     = 15;
  localparam int QUEUE_DEPTH = 2;

  // 1.0 in signed Q7.8, the cap on the minimum danger.
  localparam logic signed [WEIGHT_W-1:0] Q_ONE = 16'sd256;

  // Saturation limits of a slot value.
  localparam logic signed [WEIGHT_W:0] SAT_MAX = 17'sd32767;
  localparam logic signed [WEIGHT_W:0] SAT_MIN = -17'sd32768;

  // Work the executor carries out.
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_CALC  = 2'd2
  } cmd_kind_t;

  // One classified command in the queue.
  typedef struct packed {
    cmd_kind_t                   kind;
    logic                        map_select;
    logic [DIR_IN_W-1:0]         direction;
    logic signed [WEIGHT_W-1:0]  weight;
  } cmd_t;

  // Saturating add of two signed Q7.8 values.
  function automatic logic signed [WEIGHT_W-1:0] sat_add(
    input logic signed [WEIGHT_W-1:0] a,
    input logic signed [WEIGHT_W-1:0] b
  );
    logic signed [WEIGHT_W:0] sum;
    sum = {a[WEIGHT_W-1], a} + {b[WEIGHT_W-1], b};
    if (sum > SAT_MAX) begin
      return SAT_MAX[WEIGHT_W-1:0];
    end else if (sum < SAT_MIN) begin
      return SAT_MIN[WEIGHT_W-1:0];
    end else begin
      return sum[WEIGHT_W-1:0];
    end
  endfunction

endpackage

// File: design/csm_front.sv
// Front end of the context steering map: accepts item transfers, drops
// items that have no effect and turns the rest into queue commands.
// Depends on csm_pkg.
module csm_front
  import csm_pkg::*;
#(
  parameter int DIRECTIONS = 8
) (
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 op,
  input  logic                       map_select,
  input  logic [DIR_IN_W-1:0]        direction,
  input  logic signed [WEIGHT_W-1:0] weight,
  input  logic                       full,
  output logic                       push,
  output cmd_t                       push_cmd
);

  // Operation codes of the item transfer.
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_CALC  = 2'd2;

  logic keep;
  logic dir_ok;
  logic accepted;

  // The whole front is stalled while the queue has no free entry.
  assign in_stall = full;
  assign accepted = in_valid && !full;

  // An add aimed past the last slot changes nothing.
  assign dir_ok = ({29'd0, direction} < 32'(DIRECTIONS));

  // Classify the item into a command, or mark it as one to drop.
  always_comb begin
    push_cmd.map_select = map_select;
    push_cmd.direction  = direction;
    push_cmd.weight     = weight;
    push_cmd.kind       = CMD_CLEAR;
    keep                = 1'b0;
    case (op)
      OP_CLEAR: begin
        push_cmd.kind = CMD_CLEAR;
        keep          = 1'b1;
      end
      OP_ADD: begin
        push_cmd.kind = CMD_ADD;
        keep          = dir_ok;
      end
      OP_CALC: begin
        push_cmd.kind = CMD_CALC;
        keep          = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // A push happens only for an accepted item that does work.
  assign push = accepted && keep;

endmodule

// File: design/csm_queue.sv
// Short command queue between the front end and the executor of the
// context steering map. Depends on csm_pkg.
module csm_queue
  import csm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  // Pointer and fill count bookkeeping; pushes and pops may share a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_cmd;
        wr_ptr          <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: design/csm_back.sv
// Executor of the context steering map: holds the interest and danger
// slots, carries out clear, add and calculate commands and drives the
// result transfer. Depends on csm_pkg.
module csm_back
  import csm_pkg::*;
#(
  parameter int DIRECTIONS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  cmd_t                head_cmd,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [BEST_W-1:0]   heading,
  output logic [FORCE_W-1:0]  force_res
);

  localparam int SW     = $clog2(DIRECTIONS);
  localparam int LEAVES = 1 << SW;
  localparam int NODES  = 2 * LEAVES - 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ZERO,
    ST_PICK
  } state_t;

  state_t                      state;
  logic signed [WEIGHT_W-1:0]  interest [DIRECTIONS];
  logic signed [WEIGHT_W-1:0]  danger   [DIRECTIONS];
  logic signed [WEIGHT_W-1:0]  min_d;

  logic [SW-1:0]               dir_s;
  logic [SW-1:0]               dir_lo;
  logic [SW-1:0]               dir_hi;
  logic signed [WEIGHT_W-1:0]  share;
  logic signed [WEIGHT_W-1:0]  amount [DIRECTIONS];
  logic signed [WEIGHT_W-1:0]  sum    [DIRECTIONS];

  logic signed [WEIGHT_W-1:0]  min_node [NODES];
  logic signed [WEIGHT_W-1:0]  max_val  [NODES];
  logic [SW-1:0]               max_idx  [NODES];
  logic                        max_ok   [NODES];
  logic signed [WEIGHT_W-1:0]  min_capped;

  // Commands leave the queue only when the executor is idle.
  assign pop = (state == ST_IDLE) && head_valid;

  // Target slot and its two ring neighbors for an add.
  assign dir_s  = SW'(head_cmd.direction);
  assign dir_lo = (dir_s == '0) ? SW'(DIRECTIONS - 1) : dir_s - 1'b1;
  assign dir_hi = (dir_s == SW'(DIRECTIONS - 1)) ? '0 : dir_s + 1'b1;
  assign share  = head_cmd.weight >>> 2;

  // Each slot lane works out its own share of the add and its saturated sum.
  always_comb begin
    for (int i = 0; i < DIRECTIONS; i++) begin
      if (dir_s == SW'(i)) begin
        amount[i] = head_cmd.weight;
      end else if (dir_lo == SW'(i) || dir_hi == SW'(i)) begin
        amount[i] = share;
      end else begin
        amount[i] = '0;
      end
      sum[i] = sat_add(head_cmd.map_select ? danger[i] : interest[i], amount[i]);
    end
  end

  // Leaves of the minimum and best-interest trees; padding never wins.
  for (genvar g = 0; g < LEAVES; g++) begin : g_leaf
    if (g < DIRECTIONS) begin : g_slot
      assign min_node[LEAVES-1+g] = danger[g];
      assign max_val[LEAVES-1+g]  = interest[g];
      assign max_idx[LEAVES-1+g]  = SW'(g);
      assign max_ok[LEAVES-1+g]   = (interest[g] > 0);
    end else begin : g_pad
      assign min_node[LEAVES-1+g] = Q_ONE;
      assign max_val[LEAVES-1+g]  = '0;
      assign max_idx[LEAVES-1+g]  = '0;
      assign max_ok[LEAVES-1+g]   = 1'b0;
    end
  end

  // Inner nodes. The right child carries higher slots, so it wins the
  // best-interest compare only when strictly larger.
  for (genvar k = 0; k < LEAVES - 1; k++) begin : g_node
    logic pick_r;
    assign min_node[k] = (min_node[2*k+2] < min_node[2*k+1]) ? min_node[2*k+2]
                                                               : min_node[2*k+1];
    assign pick_r = max_ok[2*k+2] &&
                    (!max_ok[2*k+1] || (max_val[2*k+2] > max_val[2*k+1]));
    assign max_val[k] = pick_r ? max_val[2*k+2] : max_val[2*k+1];
    assign max_idx[k] = pick_r ? max_idx[2*k+2] : max_idx[2*k+1];
    assign max_ok[k]  = max_ok[2*k+2] || max_ok[2*k+1];
  end

  // The minimum danger never goes above 1.0.
  assign min_capped = (min_node[0] < Q_ONE) ? min_node[0] : Q_ONE;

  // Command sequencer, slot storage and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < DIRECTIONS; i++) begin
        interest[i] <= '0;
        danger[i]   <= '0;
      end
    end else begin
      // A taken result clears the register unless a new one loads it.
      if (out_valid && !out_stall && (state != ST_PICK)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (head_valid) begin
            case (head_cmd.kind)
              CMD_CLEAR: begin
                for (int i = 0; i < DIRECTIONS; i++) begin
                  interest[i] <= '0;
                  danger[i]   <= '0;
                end
              end
              CMD_ADD: begin
                for (int i = 0; i < DIRECTIONS; i++) begin
                  if (head_cmd.map_select) begin
                    danger[i] <= sum[i];
                  end else begin
                    interest[i] <= sum[i];
                  end
                end
              end
              CMD_CALC: begin
                min_d <= min_capped;
                state <= ST_ZERO;
              end
              default: begin
              end
            endcase
          end
        end
        ST_ZERO: begin
          // Interest is lost for good wherever danger is above the minimum.
          for (int i = 0; i < DIRECTIONS; i++) begin
            if (danger[i] > min_d) begin
              interest[i] <= '0;
            end
          end
          state <= ST_PICK;
        end
        ST_PICK: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            if (max_ok[0]) begin
              heading   <= BEST_W'(max_idx[0]);
              force_res <= max_val[0][FORCE_W-1:0];
            end else begin
              heading   <= BEST_W'(DIRECTIONS);
              force_res <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/context_steering_map.sv
// Context steering map top level: front end, command queue and executor.
// Depends on csm_pkg, csm_front, csm_queue and csm_back.
//
// The block keeps an interest map and a danger map of DIRECTIONS signed Q7.8
// slots. The front end takes one item transfer per cycle while the queue has
// room, into a two-entry command queue. Clear and add items are done in the
// idle state; a calculate passes through the idle, zero and pick states
// (minimum danger, interest masking, best-slot pick) and its result lands
// in an output register, so the next commands proceed while that result
// waits to be taken. The executor's loop sets the rate: commands are taken
// only in idle; a calculate waits in pick for the previous result to leave.
// Unused op codes and adds aimed past the last slot are taken and dropped.
module context_steering_map
  import csm_pkg::*;
#(
  parameter int DIRECTIONS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 op,
  input  logic                       map_select,
  input  logic [DIR_IN_W-1:0]        direction,
  input  logic signed [WEIGHT_W-1:0] weight,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [BEST_W-1:0]          heading,
  output logic [FORCE_W-1:0]         force_res
);

  logic full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  // Accept and classify items.
  csm_front #(
    .DIRECTIONS (DIRECTIONS)
  ) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .map_select (map_select),
    .direction  (direction),
    .weight     (weight),
    .full       (full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // Decouple the front end from the executor.
  csm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Carry out commands and deliver results.
  csm_back #(
    .DIRECTIONS (DIRECTIONS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .heading    (heading),
    .force_res  (force_res)
  );

endmodule
